>>> rtl/core/bpc_pkg.sv
// Shared types and constants for the button press classifier.
package bpc_pkg;

	localparam int CFG_W          = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int CFG_IDX_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE       = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [CFG_W-1:0] IDLE_RST       = 16'd10000;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;

	// timing thresholds handed to the classifier
	typedef struct packed {
		logic [CFG_W-1:0] debounce_ticks;
		logic [CFG_W-1:0] long_press_ticks;
		logic [CFG_W-1:0] idle_ticks;
	} cfg_t;

	// one result per tick
	typedef struct packed {
		logic settled;
		logic pressed;
		logic short_mode;
		logic long_mode;
		logic idle_flag;
		logic pressed_changed;
		logic short_changed;
		logic long_changed;
		logic idle_changed;
	} res_t;

endpackage

>>> rtl/core/bpc_core.sv
// Debouncer and press classifier state with combinational next-state logic.
module bpc_core #(
	parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          pin_level,
	input  bpc_pkg::cfg_t cfg,
	output bpc_pkg::res_t res
);

	localparam int CMP_W = (COUNT_BITS > bpc_pkg::CFG_W) ? COUNT_BITS : bpc_pkg::CFG_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic                  prev_q;
	logic [COUNT_BITS-1:0] stable_q;
	logic [COUNT_BITS-1:0] since_q;
	logic                  pressed_q, short_q, long_q, idle_q;

	logic [COUNT_BITS-1:0] stable_d, since_inc, since_d;
	logic                  settled, longtime, idling, now_pressed;
	logic                  pressed_d, short_d, long_d, idle_d;

	always_comb begin
		stable_d  = (pin_level != prev_q) ? '0 :
		            ((stable_q == CNT_MAX) ? stable_q : stable_q + 1'b1);
		since_inc = (since_q == CNT_MAX) ? since_q : since_q + 1'b1;
		settled   = CMP_W'(stable_d) > CMP_W'(cfg.debounce_ticks);
		longtime  = CMP_W'(since_inc) >= CMP_W'(cfg.long_press_ticks);
		idling    = CMP_W'(since_inc) >= CMP_W'(cfg.idle_ticks);
		now_pressed = ~pin_level;

		since_d   = since_inc;
		pressed_d = pressed_q;
		short_d   = short_q;
		long_d    = long_q;
		idle_d    = idle_q;
		if (settled) begin
			if (now_pressed != pressed_q) begin
				pressed_d = now_pressed;
				since_d   = '0;
				idle_d    = 1'b0;
				if (!now_pressed) begin
					if (long_q) begin
						if (!longtime) long_d = 1'b0;
					end else begin
						short_d = ~short_q;
					end
				end else begin
					long_d = 1'b0;
				end
			end else if (!long_q && pressed_q && longtime) begin
				long_d = 1'b1;
				idle_d = 1'b0;
			end else if (!idle_q && idling) begin
				idle_d = 1'b1;
				long_d = 1'b0;
			end
		end
	end

	always_comb begin
		res.settled         = settled;
		res.pressed         = pressed_d;
		res.short_mode      = short_d;
		res.long_mode       = long_d;
		res.idle_flag       = idle_d;
		res.pressed_changed = pressed_d ^ pressed_q;
		res.short_changed   = short_d ^ short_q;
		res.long_changed    = long_d ^ long_q;
		res.idle_changed    = idle_d ^ idle_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= 1'b0;
			stable_q  <= '0;
			since_q   <= '0;
			pressed_q <= 1'b0;
			short_q   <= 1'b0;
			long_q    <= 1'b0;
			idle_q    <= 1'b0;
		end else if (accept) begin
			prev_q    <= pin_level;
			stable_q  <= stable_d;
			since_q   <= since_d;
			pressed_q <= pressed_d;
			short_q   <= short_d;
			long_q    <= long_d;
			idle_q    <= idle_d;
		end
	end

	// idle and long mode exclude each other
	a_long_idle_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(long_q && idle_q))
		else $error("long and idle set together");

	// an unsettled tick leaves the classifier untouched
	a_unsettled_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !settled |=> pressed_q == $past(pressed_q) &&
		short_q == $past(short_q) && long_q == $past(long_q) && idle_q == $past(idle_q))
		else $error("classifier moved on unsettled tick");

	// an accepted level change restarts elapsed time
	a_change_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && settled && (now_pressed != pressed_q) |=> since_q == '0)
		else $error("elapsed time not restarted");

	// no transfer, no state change
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(stable_q) && $stable(since_q) && $stable(prev_q))
		else $error("state changed without transfer");

endmodule

>>> rtl/core/button_press_classifier_unit.sv
// Top level of the button press classifier: config registers, handshake, result register.
//
//  channel   direction  payload
//  s_axis    in         tdata[0] pin_level (0 = pressed)
//  m_axis    out        tdata[8:0] settled .. idle_changed
//  cfg       in         cfg_index selects register, cfg_data 16 bits
//
// One tick per clock unless m_axis stalls: the classifier is a single pass of increment
// and compare logic from the state registers into the result register.
// The result is valid in the cycle after the input transfer.
// The input is ready whenever the result register is empty or being drained,
// so a stall on m_axis holds one result and then back-pressures s_axis.
// Reset restores the register defaults (50, 1000, 10000) and clears all state but res_q.
module button_press_classifier_unit #(
	parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [0] pin_level, [7:1] zero
	input  logic [bpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] settled, [1] pressed, [2] short_mode, [3] long_mode, [4] idle_flag,
	// [5] pressed_changed, [6] short_changed, [7] long_changed,
	// [8] idle_changed, [15:9] zero
	output logic [bpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0]         cfg_data
);

	bpc_pkg::cfg_t cfg_q;
	bpc_pkg::res_t res_c;
	bpc_pkg::res_t res_q;
	logic          out_valid_q;
	logic          accept;

	// register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= bpc_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ticks <= bpc_pkg::LONG_PRESS_RST;
			cfg_q.idle_ticks       <= bpc_pkg::IDLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bpc_pkg::REG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg_data;
				bpc_pkg::REG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data;
				bpc_pkg::REG_IDLE:       cfg_q.idle_ticks       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	bpc_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pin_level (s_axis_tdata[0]),
		.cfg       (cfg_q),
		.res       (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0,
		res_q.idle_changed, res_q.long_changed, res_q.short_changed,
		res_q.pressed_changed, res_q.idle_flag, res_q.long_mode,
		res_q.short_mode, res_q.pressed, res_q.settled};

endmodule

>>> sim/testbench.sv
// Self-checking testbench for button_press_classifier_unit: tick stream in, flag stream out.
`timescale 1ns / 1ps

module testbench;

	localparam logic [bpc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;   // no register behind it

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// tick stream into the block
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	// [0] pin_level, [7:1] zero
	logic [bpc_pkg::IN_TDATA_W-1:0] s_axis_tdata  = '0;

	// flag stream out of the block
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	// [0] settled, [1] pressed, [2] short_mode, [3] long_mode, [4] idle_flag,
	// [5] pressed_changed, [6] short_changed, [7] long_changed, [8] idle_changed
	logic [bpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	logic                          cfg_we    = 1'b0;
	logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bpc_pkg::CFG_W-1:0]     cfg_data  = '0;

	button_press_classifier_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 50 MHz tick clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Classifier shadow: register copies and state, updated per accepted tick
	// ------------------------------------------------------------------
	logic [bpc_pkg::CFG_W-1:0] cfg_debounce;
	logic [bpc_pkg::CFG_W-1:0] cfg_long;
	logic [bpc_pkg::CFG_W-1:0] cfg_idle;

	logic                               last_pin;
	logic [bpc_pkg::COUNT_BITS_DEF-1:0] stable_ticks;
	logic [bpc_pkg::COUNT_BITS_DEF-1:0] since_change;
	logic                               is_pressed;
	logic                               in_short;
	logic                               in_long;
	logic                               is_idle;

	logic [8:0] flags_due_q [$];   // predicted flag words, oldest first
	logic       pin_q [$];         // ticks waiting for the driver

	int  ticks_pushed  = 0;
	int  results_seen  = 0;
	int  mismatches    = 0;
	bit  no_idling     = 1'b0;     // phase runs both sides without gaps
	int  send_gap      = 0;
	int  stall_left    = 0;

	string flag_names [0:8] = '{"settled", "pressed", "short_mode", "long_mode", "idle_flag",
		"pressed_changed", "short_changed", "long_changed", "idle_changed"};

	// One debounced tick; returns the flag word in tdata bit order.
	function automatic logic [8:0] classify_tick(input logic pin);
		logic was_p, was_s, was_l, was_i;
		logic settled, now_pressed, idling, held_long;
		begin
			was_p   = is_pressed;
			was_s   = in_short;
			was_l   = in_long;
			was_i   = is_idle;
			settled = 1'b0;

			// raw sample stability
			if (pin != last_pin)
				stable_ticks = '0;
			else if (stable_ticks != '1)
				stable_ticks = stable_ticks + 1'b1;
			last_pin = pin;

			// wall time since last accepted change, counts on every tick
			if (since_change != '1)
				since_change = since_change + 1'b1;

			if (stable_ticks > cfg_debounce) begin
				settled     = 1'b1;
				idling      = (since_change >= cfg_idle);
				held_long   = (since_change >= cfg_long);
				now_pressed = ~pin;   // active-low pin
				if (now_pressed != is_pressed) begin
					is_pressed   = now_pressed;
					since_change = '0;
					if (!now_pressed) begin
						// release: early release drops long mode, a plain one toggles short
						if (in_long) begin
							if (!held_long)
								in_long = 1'b0;
						end else begin
							in_short = ~in_short;
						end
					end else begin
						in_long = 1'b0;
					end
					is_idle = 1'b0;
				end else if (!in_long && is_pressed && held_long) begin
					in_long = 1'b1;
					is_idle = 1'b0;
				end else if (!is_idle && idling) begin
					is_idle = 1'b1;
					in_long = 1'b0;
				end
			end

			return {is_idle ^ was_i, in_long ^ was_l, in_short ^ was_s, is_pressed ^ was_p,
				is_idle, in_long, in_short, is_pressed, settled};
		end
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		begin
			roll = int'($urandom_range(0, 99));
			if (no_idling || roll < 50)
				return 0;
			else if (roll < 85)
				return int'($urandom_range(1, 3));
			else if (roll < 97)
				return int'($urandom_range(4, 12));
			else
				return int'($urandom_range(13, 40));
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: one tick per transfer, prediction made at acceptance
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				flags_due_q.push_back(classify_tick(s_axis_tdata[0]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					s_axis_tvalid <= 1'b0;
					send_gap      <= send_gap - 1;
				end else if (pin_q.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {{(bpc_pkg::IN_TDATA_W-1){1'b0}}, pin_q.pop_front()};
					send_gap      <= pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random back-pressure, each transfer checked against oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : flag_monitor
		logic [8:0] want;
		logic [8:0] got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen = results_seen + 1;
				got = m_axis_tdata[8:0];
				if (flags_due_q.size() == 0) begin
					$error("flag transfer with no tick pending: %b", got);
					mismatches = mismatches + 1;
				end else begin
					want = flags_due_q.pop_front();
					for (int i = 0; i < 9; i++) begin
						if (got[i] !== want[i]) begin
							$error("%s: expected %0b, got %0b", flag_names[i], want[i], got[i]);
							mismatches = mismatches + 1;
						end
					end
				end
			end
			if (stall_left != 0) begin
				m_axis_tready <= 1'b0;
				stall_left    <= stall_left - 1;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left    <= pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic push_tick(input logic pin);
		pin_q.push_back(pin);
		ticks_pushed = ticks_pushed + 1;
	endtask

	// Block until every queued tick has come back as a flag transfer.
	task automatic wait_drained();
		while (results_seen < ticks_pushed)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Register write; the shadow copy follows. Only called with the block idle.
	task automatic write_reg(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
		input logic [bpc_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			bpc_pkg::REG_DEBOUNCE:   cfg_debounce = val;
			bpc_pkg::REG_LONG_PRESS: cfg_long     = val;
			bpc_pkg::REG_IDLE:       cfg_idle     = val;
			default:        ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Button activity: runs of one level with bounce bursts, lengths scaled to
	// the current thresholds so presses are short, long, or sit into idle.
	task automatic queue_presses(input int count);
		int  left;
		int  run;
		int  span;
		logic lvl;
		left = count;
		lvl  = 1'($urandom_range(0, 1));
		span = int'(cfg_long) + int'(cfg_idle) + 4;
		if (span > 150)
			span = 150;
		while (left > 0) begin
			case ($urandom_range(0, 9))
				0, 1:    run = int'($urandom_range(1, 2));                 // contact bounce
				2, 3, 4: run = int'(cfg_debounce) +
					int'($urandom_range(1, int'(cfg_long) + 2));
				default: run = int'(cfg_debounce) + int'($urandom_range(1, span));
			endcase
			if (run > left)
				run = left;
			repeat (run)
				push_tick(lvl);
			left = left - run;
			lvl  = ~lvl;
		end
	endtask

	task automatic run_phase(input logic [bpc_pkg::CFG_W-1:0] dbn,
		input logic [bpc_pkg::CFG_W-1:0] lng,
		input logic [bpc_pkg::CFG_W-1:0] idl, input int count, input bit quiet);
		write_reg(bpc_pkg::REG_DEBOUNCE, dbn);
		write_reg(bpc_pkg::REG_LONG_PRESS, lng);
		write_reg(bpc_pkg::REG_IDLE, idl);
		no_idling = quiet;
		queue_presses(count);
		wait_drained();
	endtask

	initial begin
		cfg_debounce = bpc_pkg::DEBOUNCE_RST;
		cfg_long     = bpc_pkg::LONG_PRESS_RST;
		cfg_idle     = bpc_pkg::IDLE_RST;
		last_pin     = 1'b0;
		stable_ticks = '0;
		since_change = '0;
		is_pressed   = 1'b0;
		in_short     = 1'b0;
		in_long      = 1'b0;
		is_idle      = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// power-on thresholds: nothing settles this soon
		queue_presses(30);
		wait_drained();

		// tight thresholds to walk the classifier by hand
		write_reg(bpc_pkg::REG_DEBOUNCE, 16'd0);
		write_reg(bpc_pkg::REG_LONG_PRESS, 16'd2);
		write_reg(bpc_pkg::REG_IDLE, 16'd4);
		write_reg(REG_UNUSED, 16'hFFFF);   // dropped by the block
		repeat (4) push_tick(1'b1);        // settle released, idle comes up
		repeat (6) push_tick(1'b0);        // press, long, then idle kicks long
		repeat (2) push_tick(1'b1);        // release after idle: short mode toggles
		repeat (2) push_tick(1'b0);        // press, long stays clear
		repeat (2) push_tick(1'b1);        // short release toggles short mode
		push_tick(1'b0);                   // bounce, never stable
		push_tick(1'b1);
		push_tick(1'b0);
		push_tick(1'b1);
		repeat (4) push_tick(1'b0);        // held into long mode
		wait_drained();
		write_reg(bpc_pkg::REG_LONG_PRESS, 16'hFFFF);
		repeat (2) push_tick(1'b1);        // release now counts as early: long drops
		wait_drained();

		// random phases across the threshold range, edges included
		run_phase(16'd1, 16'd8, 16'd20, 50, 1'b0);
		run_phase(16'd0, 16'd1, 16'd1, 50, 1'b0);
		run_phase(16'd0, 16'd0, 16'd0, 40, 1'b0);
		run_phase(16'd3, 16'd12, 16'd40, 50, 1'b1);
		run_phase(16'd2, 16'd6, 16'hFFFF, 50, 1'b0);
		run_phase(16'hFFFF, 16'd3, 16'd5, 20, 1'b0);
		run_phase(16'd1, 16'd30, 16'd10, 50, 1'b0);
		for (int p = 0; p < 4; p++)
			run_phase(16'($urandom_range(0, 4)), 16'($urandom_range(1, 30)),
				16'($urandom_range(1, 60)), 50, p == 2);

		// let the clock run on so any stray transfer shows up
		repeat (8) @(posedge clk);
		if (mismatches == 0 && flags_due_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#(50_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/bpc_pkg.sv
rtl/core/bpc_core.sv
rtl/core/button_press_classifier_unit.sv
sim/testbench.sv
